// ===== src/lik_pkg.sv =====
// ----------------------------------------------------------------------------
// Leg inverse kinematics package
// Shared constants, register indexes, status codes and the stage step
// functions of the square root and divider pipelines.
// ----------------------------------------------------------------------------
package lik_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Z        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEMUR_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIBIA_LENGTH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACING_POSITIVE = 3'd5;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_CLAMPED    = 2'd1;
    localparam logic [1:0] STATUS_DEGENERATE = 2'd2;

    localparam int CORDIC_IN_W = 26;
    localparam int CORDIC_W    = 36;
    localparam int ANGLE_W     = 32;
    localparam int ATAN_TAB_LEN = 24;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    localparam logic signed [ANGLE_W-1:0] ATAN_TAB [0:ATAN_TAB_LEN-1] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    typedef struct packed {
        logic [51:0] rem;
        logic [25:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic [43:0] rem;
        logic [41:0] den;
        logic [14:0] quot;
    } div_state_t;

    // One bit of a floor square root; rem holds the input minus root squared.
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, int unsigned k);
        logic [51:0] trial;
        sqrt_state_t r;
        trial = (52'(s.root) << (k + 1)) + (52'(1) << (2 * k));
        r = s;
        if (s.rem >= trial)
        begin
            r.rem  = s.rem - trial;
            r.root = s.root | (26'(1) << k);
        end
        return r;
    endfunction

    // One quotient bit of a restoring division, most significant bit first.
    function automatic div_state_t div_step(div_state_t s, int unsigned j);
        logic [43:0] part;
        div_state_t r;
        part = (j == 0) ? s.rem : (s.rem << 1);
        r = s;
        if (part >= 44'(s.den))
        begin
            r.rem  = part - 44'(s.den);
            r.quot = s.quot | (15'(1) << (14 - j));
        end
        else
        begin
            r.rem = part;
        end
        return r;
    endfunction

endpackage

// ===== src/lik_target_if.sv =====
// ----------------------------------------------------------------------------
// Foot target channel
// Valid/ready channel carrying one foot target per transaction.
// ----------------------------------------------------------------------------
interface lik_target_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_x;
    logic signed [15:0] target_z;

    modport source (output valid, output target_x, output target_z, input ready);
    modport sink   (input valid, input target_x, input target_z, output ready);
endinterface

// ===== src/lik_angles_if.sv =====
// ----------------------------------------------------------------------------
// Joint angle channel
// Valid/ready channel carrying three joint angles and a status per transaction.
// ----------------------------------------------------------------------------
interface lik_angles_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] hip_angle;
    logic signed [15:0] knee_angle;
    logic [1:0]         status;

    modport source (output valid, output shoulder_angle, output hip_angle,
                    output knee_angle, output status, input ready);
    modport sink   (input valid, input shoulder_angle, input hip_angle,
                    input knee_angle, input status, output ready);
endinterface

// ===== src/lik_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(y, x) in radians scaled by 2^28, one iteration per register stage,
// with quadrant folding and input normalisation in front.
// ----------------------------------------------------------------------------
module lik_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [lik_pkg::CORDIC_IN_W-1:0] x,
    input  logic signed [lik_pkg::CORDIC_IN_W-1:0] y,
    output logic signed [lik_pkg::ANGLE_W-1:0]     angle
);

    localparam int QW = lik_pkg::CORDIC_IN_W + 1;
    localparam int CW = lik_pkg::CORDIC_W;
    localparam int AW = lik_pkg::ANGLE_W;

    logic signed [QW-1:0] qx_reg, qy_reg, nx_reg, ny_reg;
    logic signed [AW-1:0] qz_reg, nz_reg;
    logic                 qzero_reg, nzero_reg;
    logic [4:0]           shift_reg;

    logic signed [CW-1:0] xs_reg [0:STEPS];
    logic signed [CW-1:0] ys_reg [0:STEPS];
    logic signed [AW-1:0] zs_reg [0:STEPS];
    logic                 zero_reg [0:STEPS];

    logic [QW-1:0] mag;
    logic [4:0]    msb;

    always_comb
    begin
        mag = qx_reg | (qy_reg[QW-1] ? -qy_reg : qy_reg);
        msb = '0;
        for (int b = 0; b < QW; b++)
        begin
            if (mag[b])
            begin
                msb = 5'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qzero_reg <= (x == 0) && (y == 0);
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    qx_reg <= QW'(y);
                    qy_reg <= -(QW'(x));
                    qz_reg <= lik_pkg::HALF_PI_Q28;
                end
                else
                begin
                    qx_reg <= -(QW'(y));
                    qy_reg <= QW'(x);
                    qz_reg <= -lik_pkg::HALF_PI_Q28;
                end
            end
            else
            begin
                qx_reg <= QW'(x);
                qy_reg <= QW'(y);
                qz_reg <= '0;
            end

            nx_reg    <= qx_reg;
            ny_reg    <= qy_reg;
            nz_reg    <= qz_reg;
            nzero_reg <= qzero_reg;
            shift_reg <= 5'd30 - msb;

            xs_reg[0]   <= CW'(nx_reg) <<< shift_reg;
            ys_reg[0]   <= CW'(ny_reg) <<< shift_reg;
            zs_reg[0]   <= nz_reg;
            zero_reg[0] <= nzero_reg;

            for (int i = 0; i < STEPS; i++)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!ys_reg[i][CW-1])
                begin
                    xs_reg[i+1] <= xs_reg[i] + (ys_reg[i] >>> i);
                    ys_reg[i+1] <= ys_reg[i] - (xs_reg[i] >>> i);
                    zs_reg[i+1] <= zs_reg[i] + lik_pkg::ATAN_TAB[i];
                end
                else
                begin
                    xs_reg[i+1] <= xs_reg[i] - (ys_reg[i] >>> i);
                    ys_reg[i+1] <= ys_reg[i] + (xs_reg[i] >>> i);
                    zs_reg[i+1] <= zs_reg[i] - lik_pkg::ATAN_TAB[i];
                end
            end
        end
    end

    assign angle = zero_reg[STEPS] ? '0 : zs_reg[STEPS];

endmodule

// ===== src/leg_inverse_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// Leg inverse kinematics
// Foot target to shoulder, hip and knee angles for a two-link leg.
//
//   Channel   Kind              Payload
//   target    valid/ready in    target_x, target_z (Q8.8)
//   angles    valid/ready out   shoulder/hip/knee angle (rad*4096), status
//   cfg       write enable      cfg_index, cfg_data
//
// One transaction can enter every cycle. A transaction passes through the chain
// of square root, divider, square root and CORDIC stages. The whole pipeline
// holds while a result waits on the output register and is not taken. Reset
// clears the valid bits and sets the config registers to defaults.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lik_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lik_pkg::CFG_DATA_W-1:0]    cfg_data,
    lik_target_if.sink                        target,
    lik_angles_if.source                      angles
);

    localparam int SQ_STEPS  = 25;
    localparam int DIV_STEPS = 15;
    localparam int SIN_STEPS = 15;
    localparam int S_DIFF = 1;
    localparam int S_SQ   = 2;
    localparam int S_SUM  = S_SQ + 1;
    localparam int S_ROOT = S_SUM + SQ_STEPS;
    localparam int S_MUL  = S_ROOT + 1;
    localparam int S_DIV0 = S_MUL + 1;
    localparam int S_QUOT = S_DIV0 + DIV_STEPS;
    localparam int S_COS  = S_QUOT + 1;
    localparam int S_SIN0 = S_COS + 1;
    localparam int S_SIN  = S_SIN0 + SIN_STEPS;
    localparam int S_ANG  = S_SIN + CORDIC_STEPS + 3;
    localparam int S_OUT  = S_ANG + 1;
    localparam int IW = lik_pkg::CORDIC_IN_W;
    localparam int AW = lik_pkg::ANGLE_W;

    logic signed [15:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [15:0]        femur_length_reg, tibia_length_reg;
    logic               facing_positive_reg;
    logic [31:0]        ff_reg, tt_reg;

    logic [S_OUT:1] valid_reg;
    logic           en;

    logic signed [16:0] dx_pipe_reg [S_DIFF:S_SIN];
    logic signed [16:0] dz_pipe_reg [S_DIFF:S_SIN];
    logic               degen_pipe_reg [S_DIFF:S_ANG];
    logic [31:0]        dx2_reg, dz2_reg;
    logic [30:0]        oy2_reg;
    logic [33:0]        l2_pipe_reg [S_SUM:S_ROOT];
    lik_pkg::sqrt_state_t sqs_reg [S_SUM:S_ROOT];
    lik_pkg::sqrt_state_t sql_reg [S_SUM:S_ROOT];
    logic [24:0]        sd_pipe_reg [S_MUL:S_SIN];
    logic [40:0]        den_reg [0:1];
    logic signed [35:0] num_reg [0:1];
    lik_pkg::div_state_t div_reg [0:1][S_DIV0:S_QUOT];
    logic               neg_pipe_reg [0:1][S_DIV0:S_QUOT];
    logic               clamp_pipe_reg [0:1][S_DIV0:S_ANG];
    logic signed [15:0] cos_pipe_reg [0:1][S_COS:S_SIN];
    lik_pkg::sqrt_state_t sin_reg [0:1][S_SIN0:S_SIN];

    logic signed [15:0] shoulder_reg, hip_reg, knee_reg;
    logic [1:0]         status_reg;

    logic signed [16:0] dx_in, dz_in;
    logic signed [33:0] dx_sq, dz_sq;
    logic signed [31:0] oy_sq;
    logic [32:0]        s2_sum;
    logic [33:0]        l2_sum;
    logic [24:0]        len;
    logic [35:0]        num_mag [0:1];
    logic [43:0]        m_val [0:1];
    logic [41:0]        den2 [0:1];
    logic [14:0]        cos_mag [0:1];
    logic signed [15:0] cos_val [0:1];
    logic [15:0]        cos_abs [0:1];
    logic [31:0]        cos_sq [0:1];

    logic signed [IW-1:0] alpha_x, alpha_y, beta_x, beta_y, gamma_x, gamma_y;
    logic signed [IW-1:0] tilt_x, tilt_y;
    logic signed [16:0]   dxs, dzs;
    logic signed [AW-1:0] alpha_z, beta_z, gamma_z, tilt_z;
    logic signed [33:0]   base, shoulder_sum, hip_sum, knee_sum;
    logic signed [33:0]   half_pi, round_bias;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg        <= '0;
            origin_y_reg        <= '0;
            origin_z_reg        <= '0;
            femur_length_reg    <= 16'd2560;
            tibia_length_reg    <= 16'd2560;
            facing_positive_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lik_pkg::CFG_ORIGIN_X:        origin_x_reg        <= cfg_data;
                lik_pkg::CFG_ORIGIN_Y:        origin_y_reg        <= cfg_data;
                lik_pkg::CFG_ORIGIN_Z:        origin_z_reg        <= cfg_data;
                lik_pkg::CFG_FEMUR_LENGTH:    femur_length_reg    <= cfg_data;
                lik_pkg::CFG_TIBIA_LENGTH:    tibia_length_reg    <= cfg_data;
                lik_pkg::CFG_FACING_POSITIVE: facing_positive_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ff_reg <= femur_length_reg * femur_length_reg;
        tt_reg <= tibia_length_reg * tibia_length_reg;
    end

    assign en           = !valid_reg[S_OUT] || angles.ready;
    assign target.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[S_OUT-1:1], target.valid};
        end
    end

    always_comb
    begin
        dx_in  = 17'(target.target_x) - 17'(origin_x_reg);
        dz_in  = 17'(target.target_z) - 17'(origin_z_reg);
        dx_sq  = dx_pipe_reg[S_DIFF] * dx_pipe_reg[S_DIFF];
        dz_sq  = dz_pipe_reg[S_DIFF] * dz_pipe_reg[S_DIFF];
        oy_sq  = origin_y_reg * origin_y_reg;
        s2_sum = 33'(dx2_reg) + 33'(dz2_reg);
        l2_sum = 34'(s2_sum) + 34'(oy2_reg);
        len    = sql_reg[S_ROOT].root[24:0];
        for (int l = 0; l < 2; l++)
        begin
            num_mag[l] = num_reg[l][35] ? 36'(-num_reg[l]) : 36'(num_reg[l]);
            m_val[l]   = 44'({num_mag[l][34:0], 8'h00});
            den2[l]    = {den_reg[l], 1'b0};
            cos_mag[l] = clamp_pipe_reg[l][S_QUOT] ? lik_pkg::ONE_Q14
                                                   : div_reg[l][S_QUOT].quot;
            cos_val[l] = neg_pipe_reg[l][S_QUOT] ? -$signed({1'b0, cos_mag[l]})
                                                 : $signed({1'b0, cos_mag[l]});
            cos_abs[l] = cos_pipe_reg[l][S_COS][15] ? 16'(-cos_pipe_reg[l][S_COS])
                                                    : 16'(cos_pipe_reg[l][S_COS]);
            cos_sq[l]  = cos_abs[l] * cos_abs[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_pipe_reg[S_DIFF]    <= dx_in;
            dz_pipe_reg[S_DIFF]    <= dz_in;
            degen_pipe_reg[S_DIFF] <= ((dx_in == 0) && (dz_in == 0))
                                      || (femur_length_reg == '0)
                                      || (tibia_length_reg == '0);
            for (int s = S_DIFF + 1; s <= S_SIN; s++)
            begin
                dx_pipe_reg[s] <= dx_pipe_reg[s-1];
                dz_pipe_reg[s] <= dz_pipe_reg[s-1];
            end
            for (int s = S_DIFF + 1; s <= S_ANG; s++)
            begin
                degen_pipe_reg[s] <= degen_pipe_reg[s-1];
            end

            dx2_reg <= dx_sq[31:0];
            dz2_reg <= dz_sq[31:0];
            oy2_reg <= oy_sq[30:0];

            sqs_reg[S_SUM]     <= '{rem: 52'({s2_sum, 16'h0000}), root: '0};
            sql_reg[S_SUM]     <= '{rem: 52'({l2_sum, 16'h0000}), root: '0};
            l2_pipe_reg[S_SUM] <= l2_sum;
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                sqs_reg[S_SUM+j+1]     <= lik_pkg::sqrt_step(sqs_reg[S_SUM+j], SQ_STEPS - 1 - j);
                sql_reg[S_SUM+j+1]     <= lik_pkg::sqrt_step(sql_reg[S_SUM+j], SQ_STEPS - 1 - j);
                l2_pipe_reg[S_SUM+j+1] <= l2_pipe_reg[S_SUM+j];
            end

            sd_pipe_reg[S_MUL] <= sqs_reg[S_ROOT].root[24:0];
            for (int s = S_MUL + 1; s <= S_SIN; s++)
            begin
                sd_pipe_reg[s] <= sd_pipe_reg[s-1];
            end
            den_reg[0] <= 41'(femur_length_reg) * 41'(len);
            den_reg[1] <= 41'(tibia_length_reg) * 41'(len);
            num_reg[0] <= 36'(ff_reg) + 36'(l2_pipe_reg[S_ROOT]) - 36'(tt_reg);
            num_reg[1] <= 36'(tt_reg) + 36'(l2_pipe_reg[S_ROOT]) - 36'(ff_reg);

            for (int l = 0; l < 2; l++)
            begin
                div_reg[l][S_DIV0]        <= '{rem: m_val[l], den: den2[l], quot: '0};
                neg_pipe_reg[l][S_DIV0]   <= num_reg[l][35];
                clamp_pipe_reg[l][S_DIV0] <= m_val[l] > 44'(den2[l]);
                for (int j = 0; j < DIV_STEPS; j++)
                begin
                    div_reg[l][S_DIV0+j+1]      <= lik_pkg::div_step(div_reg[l][S_DIV0+j], j);
                    neg_pipe_reg[l][S_DIV0+j+1] <= neg_pipe_reg[l][S_DIV0+j];
                end
                for (int s = S_DIV0 + 1; s <= S_ANG; s++)
                begin
                    clamp_pipe_reg[l][s] <= clamp_pipe_reg[l][s-1];
                end

                cos_pipe_reg[l][S_COS] <= cos_val[l];
                for (int s = S_COS + 1; s <= S_SIN; s++)
                begin
                    cos_pipe_reg[l][s] <= cos_pipe_reg[l][s-1];
                end

                sin_reg[l][S_SIN0] <= '{rem: 52'(29'h1000_0000 - cos_sq[l][28:0]),
                                        root: '0};
                for (int j = 0; j < SIN_STEPS; j++)
                begin
                    sin_reg[l][S_SIN0+j+1] <= lik_pkg::sqrt_step(sin_reg[l][S_SIN0+j],
                                                                 SIN_STEPS - 1 - j);
                end
            end
        end
    end

    always_comb
    begin
        dxs     = dx_pipe_reg[S_SIN];
        dzs     = dz_pipe_reg[S_SIN];
        alpha_y = IW'($signed({origin_y_reg, 8'h00}));
        alpha_x = $signed(IW'(sd_pipe_reg[S_SIN]));
        beta_y  = $signed(IW'(sin_reg[0][S_SIN].root[14:0]));
        beta_x  = IW'(cos_pipe_reg[0][S_SIN]);
        gamma_y = $signed(IW'(sin_reg[1][S_SIN].root[14:0]));
        gamma_x = IW'(cos_pipe_reg[1][S_SIN]);
        tilt_y  = dzs[16] ? IW'(-dxs) : IW'(dxs);
        tilt_x  = dzs[16] ? IW'(-dzs) : IW'(dzs);
    end

    lik_cordic #(.STEPS(CORDIC_STEPS)) u_alpha
    (
        .clk   (clk),
        .en    (en),
        .x     (alpha_x),
        .y     (alpha_y),
        .angle (alpha_z)
    );

    lik_cordic #(.STEPS(CORDIC_STEPS)) u_beta
    (
        .clk   (clk),
        .en    (en),
        .x     (beta_x),
        .y     (beta_y),
        .angle (beta_z)
    );

    lik_cordic #(.STEPS(CORDIC_STEPS)) u_gamma
    (
        .clk   (clk),
        .en    (en),
        .x     (gamma_x),
        .y     (gamma_y),
        .angle (gamma_z)
    );

    lik_cordic #(.STEPS(CORDIC_STEPS)) u_tilt
    (
        .clk   (clk),
        .en    (en),
        .x     (tilt_x),
        .y     (tilt_y),
        .angle (tilt_z)
    );

    always_comb
    begin
        half_pi      = 34'(lik_pkg::HALF_PI_Q28);
        round_bias   = 34'sd32768;
        base         = facing_positive_reg ? half_pi : -half_pi;
        shoulder_sum = base - 34'(tilt_z) + round_bias;
        hip_sum      = 34'(alpha_z) - 34'(beta_z) + half_pi + round_bias;
        knee_sum     = 34'(alpha_z) + 34'(gamma_z) + half_pi + round_bias;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (degen_pipe_reg[S_ANG])
            begin
                shoulder_reg <= '0;
                hip_reg      <= '0;
                knee_reg     <= '0;
                status_reg   <= lik_pkg::STATUS_DEGENERATE;
            end
            else
            begin
                shoulder_reg <= shoulder_sum[31:16];
                hip_reg      <= hip_sum[31:16];
                knee_reg     <= knee_sum[31:16];
                status_reg   <= (clamp_pipe_reg[0][S_ANG] || clamp_pipe_reg[1][S_ANG])
                                ? lik_pkg::STATUS_CLAMPED : lik_pkg::STATUS_OK;
            end
        end
    end

    assign angles.valid          = valid_reg[S_OUT];
    assign angles.shoulder_angle = shoulder_reg;
    assign angles.hip_angle      = hip_reg;
    assign angles.knee_angle     = knee_reg;
    assign angles.status         = status_reg;

endmodule

// ===== tb/tb_leg_inverse_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// Leg inverse kinematics testbench
// Drives foot targets through several shoulder and segment settings, with
// random idling on both channels and one long output stall, and compares
// every set of joint angles with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_leg_inverse_kinematics_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 3000;
    localparam int CORDIC_STEPS_TB = 16;

    typedef struct {
        logic signed [15:0] shoulder;
        logic signed [15:0] hip;
        logic signed [15:0] knee;
        logic [1:0]         status;
    } joint_angles_t;

    class leg_angle_scoreboard;
        longint org_x, org_y, org_z, femur, tibia;
        bit facing;
        joint_angles_t pending[$];
        int errors;

        localparam longint QUARTER_TURN = 64'sd421657428;
        longint atan_steps[24] = '{
            210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
            4193963, 2097109, 1048571, 524287, 262144, 131072,
            65536, 32768, 16384, 8192, 4096, 2048,
            1024, 512, 256, 128, 64, 32
        };

        function void reset_regs();
            org_x = 0; org_y = 0; org_z = 0;
            femur = 2560; tibia = 2560; facing = 0;
        endfunction

        function void write_reg(logic [lik_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
            case (idx)
                lik_pkg::CFG_ORIGIN_X:        org_x = longint'($signed(data));
                lik_pkg::CFG_ORIGIN_Y:        org_y = longint'($signed(data));
                lik_pkg::CFG_ORIGIN_Z:        org_z = longint'($signed(data));
                lik_pkg::CFG_FEMUR_LENGTH:    femur = longint'(data);
                lik_pkg::CFG_TIBIA_LENGTH:    tibia = longint'(data);
                lik_pkg::CFG_FACING_POSITIVE: facing = data[0];
                default: ;
            endcase
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint vector_angle(longint y, longint x);
            longint z, t, nx, ny;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = QUARTER_TURN;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -QUARTER_TURN;
                end
            end
            while ((x < 0 ? -x : x) < (64'sd1 <<< 30) && (y < 0 ? -y : y) < (64'sd1 <<< 30))
            begin
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < CORDIC_STEPS_TB && i < 24; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += atan_steps[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= atan_steps[i];
                end
                x = nx;
                y = ny;
            end
            return z;
        endfunction

        function longint cosine_angle(longint num, longint den, ref bit clamped);
            longint m, c;
            longint unsigned s;
            m = num < 0 ? -num : num;
            if (m > den)
            begin
                c = 16384;
                clamped = 1;
            end
            else
            begin
                c = (m * 16384) / den;
            end
            if (num < 0)
                c = -c;
            s = floor_sqrt(longint'(64'sd1 <<< 28) - c * c);
            return vector_angle(longint'(s), c);
        endfunction

        function logic signed [15:0] round_angle(longint q28);
            longint v;
            v = (q28 + 32768) >>> 16;
            return v[15:0];
        endfunction

        function void note_target(logic signed [15:0] tx, logic signed [15:0] tz);
            longint dx, dz, s2, l2, sd, len, alpha, beta, gamma, tilt, base;
            bit clamped;
            joint_angles_t e;
            clamped = 0;
            dx = longint'(tx) - org_x;
            dz = longint'(tz) - org_z;
            if ((dx == 0 && dz == 0) || femur == 0 || tibia == 0)
            begin
                e = '{16'sd0, 16'sd0, 16'sd0, lik_pkg::STATUS_DEGENERATE};
            end
            else
            begin
                s2 = dx * dx + dz * dz;
                l2 = s2 + org_y * org_y;
                sd = longint'(floor_sqrt(s2 << 16));
                len = longint'(floor_sqrt(l2 << 16));
                alpha = vector_angle(org_y * 256, sd);
                beta = cosine_angle((femur * femur + l2 - tibia * tibia) * 256,
                                    2 * femur * len, clamped);
                gamma = cosine_angle((tibia * tibia + l2 - femur * femur) * 256,
                                     2 * tibia * len, clamped);
                tilt = vector_angle(dz < 0 ? -dx : dx, dz < 0 ? -dz : dz);
                base = facing ? QUARTER_TURN : -QUARTER_TURN;
                e.shoulder = round_angle(base - tilt);
                e.hip = round_angle(alpha - beta + QUARTER_TURN);
                e.knee = round_angle(alpha + gamma + QUARTER_TURN);
                e.status = clamped ? lik_pkg::STATUS_CLAMPED : lik_pkg::STATUS_OK;
            end
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_angles(joint_angles_t r);
            joint_angles_t e;
            if (pending.size() == 0)
            begin
                report("unexpected transaction, status", r.status, -1);
                return;
            end
            e = pending.pop_front();
            if (r.shoulder !== e.shoulder) report("shoulder_angle", r.shoulder, e.shoulder);
            if (r.hip !== e.hip)           report("hip_angle", r.hip, e.hip);
            if (r.knee !== e.knee)         report("knee_angle", r.knee, e.knee);
            if (r.status !== e.status)     report("status", r.status, e.status);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [lik_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lik_pkg::CFG_DATA_W-1:0]  cfg_data;

    lik_target_if target();
    lik_angles_if angles();

    leg_inverse_kinematics_top #(.CORDIC_STEPS(CORDIC_STEPS_TB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .target    (target),
        .angles    (angles)
    );

    leg_angle_scoreboard board;
    int send_idle_pct;
    int take_idle_pct;
    int hold_off;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        joint_angles_t r;
        if (rst_n)
        begin
            if (angles.valid && angles.ready)
            begin
                r = '{angles.shoulder_angle, angles.hip_angle, angles.knee_angle,
                      angles.status};
                board.check_angles(r);
            end
            if (hold_off > 0)
            begin
                hold_off--;
                angles.ready <= 1'b0;
            end
            else
            begin
                angles.ready <= ($urandom_range(0, 99) >= take_idle_pct);
            end
        end
        else
        begin
            angles.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((angles.valid && angles.ready) || (target.valid && target.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task write_reg(logic [lik_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    task set_geometry(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                      logic [15:0] fl, logic [15:0] tl, bit fp);
        write_reg(lik_pkg::CFG_ORIGIN_X, ox);
        write_reg(lik_pkg::CFG_ORIGIN_Y, oy);
        write_reg(lik_pkg::CFG_ORIGIN_Z, oz);
        write_reg(lik_pkg::CFG_FEMUR_LENGTH, fl);
        write_reg(lik_pkg::CFG_TIBIA_LENGTH, tl);
        write_reg(lik_pkg::CFG_FACING_POSITIVE, {15'($urandom), fp});
        cfg_write <= 1'b0;
    endtask

    task send_target(logic signed [15:0] tx, logic signed [15:0] tz);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            target.valid <= 1'b0;
            @(posedge clk);
        end
        target.valid <= 1'b1;
        target.target_x <= tx;
        target.target_z <= tz;
        do
            @(posedge clk);
        while (!(target.valid && target.ready));
        board.note_target(tx, tz);
    endtask

    task wait_idle();
        target.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task random_targets(int count);
        int span, px, pz;
        span = int'(board.femur + board.tibia) + 256;
        if (span > 32767)
            span = 32767;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0: send_target(board.org_x[15:0], board.org_z[15:0]);
                1, 2, 3, 4: send_target(16'($urandom), 16'($urandom));
                default:
                begin
                    px = int'(board.org_x) + $urandom_range(0, 2 * span) - span;
                    pz = int'(board.org_z) + $urandom_range(0, 2 * span) - span;
                    send_target(px[15:0], pz[15:0]);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        target.valid <= 1'b0;
        target.target_x <= '0;
        target.target_z <= '0;
        board = new();
        board.reset_regs();
        send_idle_pct = 12;
        take_idle_pct = 74;
        hold_off = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_target(16'sd0, 16'sd0);
        send_target(16'sd256, 16'sd0);
        send_target(-16'sd256, 16'sd0);
        send_target(16'sd0, 16'sd256);
        send_target(16'sd0, -16'sd256);
        send_target(16'sd1, 16'sd0);
        send_target(16'sd1, 16'sd1);
        send_target(-16'sd1, -16'sd1);
        send_target(16'sd5120, 16'sd0);
        send_target(16'sd100, 16'sd0);
        send_target(16'sd32767, 16'sd0);
        send_target(16'sd32767, 16'sd32767);
        send_target(-16'sd32768, -16'sd32768);
        send_target(16'sd32767, -16'sd32768);
        send_target(-16'sd32768, 16'sd32767);
        send_target(16'sd3000, -16'sd2000);
        wait_idle();

        set_geometry(16'sd256, -16'sd1024, 16'sd128, 16'd2000, 16'd3000, 1'b1);
        random_targets(200);
        hold_off = 500;
        random_targets(200);
        wait_idle();

        set_geometry(-16'sd32768, 16'sd32767, 16'sd32767, 16'd65535, 16'd65535, 1'b0);
        random_targets(250);
        wait_idle();

        send_idle_pct = 74;
        take_idle_pct = 12;
        set_geometry(16'sd32767, -16'sd32768, -16'sd32768, 16'd1, 16'd65535, 1'b1);
        random_targets(250);
        wait_idle();

        set_geometry(16'sd0, 16'sd512, 16'sd0, 16'd0, 16'd100, 1'b0);
        random_targets(40);
        wait_idle();

        set_geometry(-16'sd500, 16'sd2000, 16'sd300, 16'd2560, 16'd3000, 1'b0);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        cfg_write <= 1'b0;
        random_targets(400);
        wait_idle();

        send_idle_pct = 0;
        take_idle_pct = 0;
        set_geometry(16'sd1000, 16'sd0, -16'sd700, 16'd3000, 16'd1500, 1'b1);
        random_targets(450);
        wait_idle();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/lik_pkg.sv
src/lik_target_if.sv
src/lik_angles_if.sv
src/lik_cordic.sv
src/leg_inverse_kinematics_top.sv
tb/tb_leg_inverse_kinematics_top.sv
